@@ rtl/core/sct_pkg.sv @@
package sct_pkg;

    // Fixed-point constants (angles in Q32, results in Q30)
    localparam logic [40:0] HALF_PI_Q32 = 41'h0_01921FB544;
    localparam logic [39:0] PI_Q32      = 40'h03243F6A89;
    localparam logic [39:0] TWO_PI_Q32  = 40'h06487ED511;
    localparam logic [30:0] ONE_Q30     = 31'h40000000;

    // Result range, signed Q2.30
    localparam logic signed [31:0] VALUE_MAX = 32'sh40000000;
    localparam logic signed [31:0] VALUE_MIN = -32'sh40000000;

    // Pipeline depth of each section
    localparam int RED_STAGES   = 9;
    localparam int POLY_STAGES  = 18;
    localparam int RED_STEPS    = 6;

    // Horner coefficients: six constant divisors, then the final halving
    localparam int NUM_DIV      = 6;
    localparam int NUM_TERMS    = 7;
    localparam int Q_W          = 34;

    localparam logic [7:0] DIVISOR [NUM_DIV] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12
    };

    // floor(2^shift / d); the estimate is low by at most one
    localparam logic [31:0] RECIP [NUM_DIV] = '{
        32'd3020636340, 32'd4164816771, 32'd3054198966,
        32'd2454267026, 32'd2290649224, 32'd2863311530
    };

    localparam int unsigned RECIP_SHIFT [NUM_DIV] = '{39, 39, 38, 37, 36, 35};

    typedef logic [Q_W-1:0] t_quot [NUM_TERMS];

endpackage

@@ rtl/core/sine_cosine_taylor_core.sv @@
// Channel  | Dir | Ports            | Word
// ---------+-----+------------------+----------------------------------------
// s_axis   | in  | tvalid/tready    | tdata: angle Q8.24; tuser: kind
// m_axis   | out | tvalid/tready    | tdata: value Q2.30
//
// One word per cycle sustained while m_axis_tready holds high; 28 register stages
// in all, among them the 6-step modulo reduction and the seven multiply and
// subtract pairs of the Horner chain, one register each.
// Reset is synchronous, active low, and clears the stage valid bits only.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up under a stalled output and s_axis_tready stays high while any stage is free.
module sine_cosine_taylor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] angle
    input  logic        i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] value
);

    localparam int NS = sct_pkg::RED_STAGES + sct_pkg::POLY_STAGES + 1;

    logic [NS-1:0]      r_v;
    logic [NS-1:0]      w_en;
    logic [31:0]        w_x30;
    logic               w_red_neg;
    logic signed [35:0] w_r;
    logic               w_poly_neg;
    logic signed [35:0] n_val;
    logic [31:0]        n_out;
    logic [31:0]        r_out;

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    sct_reduce u_reduce (
        .i_clk    (i_clk),
        .i_en     (w_en[sct_pkg::RED_STAGES-1:0]),
        .i_angle  (i_s_axis_tdata),
        .i_kind   (i_s_axis_tuser),
        .o_x30    (w_x30),
        .o_negate (w_red_neg)
    );

    sct_poly u_poly (
        .i_clk    (i_clk),
        .i_en     (w_en[NS-2:sct_pkg::RED_STAGES]),
        .i_x30    (w_x30),
        .i_negate (w_red_neg),
        .o_r      (w_r),
        .o_negate (w_poly_neg)
    );

    // Sign fold and clamp to [-1.0, 1.0]
    always_comb begin
        n_val = w_poly_neg ? -w_r : w_r;
        if (n_val > 36'(sct_pkg::VALUE_MAX)) begin
            n_out = sct_pkg::VALUE_MAX;
        end else if (n_val < 36'(sct_pkg::VALUE_MIN)) begin
            n_out = sct_pkg::VALUE_MIN;
        end else begin
            n_out = n_val[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_v[NS-1];
    assign o_m_axis_tdata  = r_out;

`ifndef SYNTH
    // An empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> o_s_axis_tready)
        else $error("input stalled with output register empty");

    // An accepted word lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[0])
        else $error("accepted word lost at pipeline entry");

    // Results stay within [-1.0, 1.0]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata) <= sct_pkg::VALUE_MAX &&
                             $signed(o_m_axis_tdata) >= sct_pkg::VALUE_MIN))
        else $error("result outside unit range");
`endif

endmodule

@@ rtl/core/sct_reduce.sv @@
module sct_reduce (
    input  logic                            i_clk,
    input  logic [sct_pkg::RED_STAGES-1:0]  i_en,
    input  logic [31:0]                     i_angle,
    input  logic                            i_kind,
    output logic [31:0]                     o_x30,
    output logic                            o_negate
);

    logic [40:0] r_a;
    logic [40:0] n_a;
    logic [39:0] r_m [sct_pkg::RED_STEPS+1];
    logic [39:0] n_abs;
    logic [31:0] r_x30;
    logic        r_neg;
    logic [39:0] n_fold;

    // Widen Q8.24 to Q32 and apply the sine offset
    always_comb begin
        n_a = {i_angle[31], i_angle, 8'h00};
        if (i_kind) begin
            n_a = n_a - sct_pkg::HALF_PI_Q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a <= n_a;
        end
    end

    // Magnitude
    always_comb begin
        n_abs = r_a[40] ? 40'(-r_a) : r_a[39:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_m[0] <= n_abs;
        end
    end

    // Restoring reduction modulo 2*pi, one quotient bit per stage
    for (genvar i = 0; i < sct_pkg::RED_STEPS; i++) begin : g_mod
        localparam logic [39:0] STEP_K = sct_pkg::TWO_PI_Q32 << (sct_pkg::RED_STEPS - 1 - i);

        always_ff @(posedge i_clk) begin
            if (i_en[2+i]) begin
                if (r_m[i] >= STEP_K) begin
                    r_m[i+1] <= r_m[i] - STEP_K;
                end else begin
                    r_m[i+1] <= r_m[i];
                end
            end
        end
    end

    // Half-turn fold into [0, pi)
    always_comb begin
        n_fold = r_m[sct_pkg::RED_STEPS];
        if (n_fold >= sct_pkg::PI_Q32) begin
            n_fold = n_fold - sct_pkg::PI_Q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[sct_pkg::RED_STAGES-1]) begin
            r_x30 <= n_fold[33:2];
            r_neg <= (r_m[sct_pkg::RED_STEPS] >= sct_pkg::PI_Q32);
        end
    end

    assign o_x30    = r_x30;
    assign o_negate = r_neg;

endmodule

@@ rtl/core/sct_poly.sv @@
module sct_poly (
    input  logic                             i_clk,
    input  logic [sct_pkg::POLY_STAGES-1:0]  i_en,
    input  logic [31:0]                      i_x30,
    input  logic                             i_negate,
    output logic signed [35:0]               o_r,
    output logic                             o_negate
);

    localparam int NT = sct_pkg::NUM_TERMS;
    localparam int QW = sct_pkg::Q_W;

    // Square
    logic [63:0]    r_sq;
    logic           r_neg0;
    // Reciprocal products
    logic [QW-1:0]  r_x2_1;
    logic [65:0]    r_pr [sct_pkg::NUM_DIV];
    logic           r_neg1;
    // Quotient estimates
    logic [QW-1:0]  r_x2_2;
    logic [QW-1:0]  r_q0  [sct_pkg::NUM_DIV];
    logic [QW-1:0]  r_q0d [sct_pkg::NUM_DIV];
    logic           r_neg2;
    // Corrected quotients
    sct_pkg::t_quot r_q;
    logic           r_neg3;

    // Horner chain, multiply then subtract per term
    sct_pkg::t_quot       r_mq   [NT];
    logic [64:0]          r_mp   [NT];
    logic                 r_mneg [NT];
    sct_pkg::t_quot       r_hq   [NT];
    logic signed [35:0]   r_sd   [NT];
    logic                 r_sneg [NT];

    sct_pkg::t_quot       w_q    [NT];
    logic [30:0]          w_t    [NT];
    logic                 w_neg  [NT];

    logic [QW-1:0]        n_q0   [sct_pkg::NUM_DIV];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sq   <= 64'(i_x30) * 64'(i_x30);
            r_neg0 <= i_negate;
        end
    end

    // x^2 in Q30 times each reciprocal
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x2_1 <= r_sq[63:30];
            r_neg1 <= r_neg0;
            for (int i = 0; i < sct_pkg::NUM_DIV; i++) begin
                r_pr[i] <= 66'(r_sq[63:30]) * 66'(sct_pkg::RECIP[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < sct_pkg::NUM_DIV; i++) begin
            n_q0[i] = QW'(r_pr[i] >> sct_pkg::RECIP_SHIFT[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_x2_2 <= r_x2_1;
            r_neg2 <= r_neg1;
            for (int i = 0; i < sct_pkg::NUM_DIV; i++) begin
                r_q0[i]  <= n_q0[i];
                r_q0d[i] <= QW'(n_q0[i] * QW'(sct_pkg::DIVISOR[i]));
            end
        end
    end

    // Correct the low-by-one estimate; last term is x^2 halved
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_neg3 <= r_neg2;
            for (int i = 0; i < sct_pkg::NUM_DIV; i++) begin
                r_q[i] <= r_q0[i]
                        + QW'((r_x2_2 - r_q0d[i]) >= QW'(sct_pkg::DIVISOR[i]));
            end
            r_q[NT-1] <= {1'b0, r_x2_2[QW-1:1]};
        end
    end

    assign w_q[0]   = r_q;
    assign w_t[0]   = sct_pkg::ONE_Q30;
    assign w_neg[0] = r_neg3;

    for (genvar j = 0; j < NT; j++) begin : g_horner
        // q * t
        always_ff @(posedge i_clk) begin
            if (i_en[4+2*j]) begin
                r_mq[j]   <= w_q[j];
                r_mp[j]   <= 65'(w_q[j][j]) * 65'(w_t[j]);
                r_mneg[j] <= w_neg[j];
            end
        end

        // 1 - q*t
        always_ff @(posedge i_clk) begin
            if (i_en[5+2*j]) begin
                r_hq[j]   <= r_mq[j];
                r_sd[j]   <= 36'sh040000000 - $signed({1'b0, r_mp[j][64:30]});
                r_sneg[j] <= r_mneg[j];
            end
        end

        if (j < NT - 1) begin : g_link
            assign w_q[j+1]   = r_hq[j];
            assign w_t[j+1]   = r_sd[j][30:0];
            assign w_neg[j+1] = r_sneg[j];
        end
    end

    assign o_r      = r_sd[NT-1];
    assign o_negate = r_sneg[NT-1];

endmodule

@@ test/tb_sine_cosine_taylor_core.sv @@
module tb_sine_cosine_taylor_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;   // a little over the pipeline depth
    localparam int LONG_HOLD   = 400;

    // Kinds carried on tuser
    localparam logic KIND_COS = 1'b0;
    localparam logic KIND_SIN = 1'b1;

    // Handy angles in Q8.24
    localparam logic [31:0] ANG_HALF_PI = 32'h01921FB5;
    localparam logic [31:0] ANG_PI      = 32'h03243F6A;
    localparam logic [31:0] ANG_TWO_PI  = 32'h06487ED5;
    localparam int unsigned ANG_SPAN    = 32'h1921FB54;  // about 8*pi

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;    // [31:0] angle
    logic        i_s_axis_tuser  = 1'b0;  // [0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // [31:0] value

    sine_cosine_taylor_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predicts each result in order and checks what comes out
    class sincos_scoreboard;
        typedef struct {
            logic [31:0] angle;
            logic        kind;
            logic [31:0] value;
        } t_pending;

        t_pending awaited[$];
        int       words_in;
        int       fails;

        // Q8.24 angle in, Q2.30 cosine or sine out
        static function logic [31:0] taylor_q30(logic [31:0] angle, logic kind);
            longint          a;
            longint          r;
            longint unsigned m;
            longint unsigned x30;
            longint unsigned x2;
            longint unsigned q;
            longint unsigned t;
            longint unsigned p;
            longint unsigned one;
            bit              flip;
            one  = 64'h4000_0000;
            flip = 1'b0;
            a = longint'($signed(angle));
            a = a * 256;
            if (kind == KIND_SIN) begin
                a = a - longint'(sct_pkg::HALF_PI_Q32);
            end
            m = (a < 0) ? longint'(-a) : longint'(a);
            m = m % longint'(sct_pkg::TWO_PI_Q32);
            // fold the second half-turn down and flip the sign
            if (m >= longint'(sct_pkg::PI_Q32)) begin
                m    = m - longint'(sct_pkg::PI_Q32);
                flip = 1'b1;
            end
            x30 = m >> 2;
            x2  = (x30 * x30) >> 30;
            // nested Horner chain, innermost divisor first
            t = one;
            for (int i = 0; i < sct_pkg::NUM_DIV; i++) begin
                q = x2 / longint'(sct_pkg::DIVISOR[i]);
                t = one - ((q * t) >> 30);
            end
            p = ((x2 / 2) * t) >> 30;
            r = longint'(one) - longint'(p);
            if (flip) begin
                r = -r;
            end
            if (r > longint'(sct_pkg::VALUE_MAX)) begin
                r = longint'(sct_pkg::VALUE_MAX);
            end
            if (r < longint'(sct_pkg::VALUE_MIN)) begin
                r = longint'(sct_pkg::VALUE_MIN);
            end
            return r[31:0];
        endfunction

        function void note_angle(logic [31:0] angle, logic kind);
            t_pending e;
            e.angle = angle;
            e.kind  = kind;
            e.value = taylor_q30(angle, kind);
            awaited.push_back(e);
            words_in++;
        endfunction

        function void check_value(logic [31:0] value);
            t_pending e;
            if (awaited.size() == 0) begin
                fails++;
                $display("%0t: unexpected word, expected none, actual %h", $time, value);
                return;
            end
            e = awaited.pop_front();
            if (value !== e.value) begin
                fails++;
                $display("%0t: value mismatch (angle %h kind %0d), expected %h, actual %h",
                         $time, e.angle, e.kind, e.value, value);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    sincos_scoreboard sb = new();
    bit steady     = 1'b0;   // no idling on either side while set
    bit hold_taken = 1'b0;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL sine_cosine_taylor_core");
        $finish;
    end

    // Output side: check accepted words, stall at random, one long hold
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                sb.check_value(o_m_axis_tdata);
            end
            if (!i_rst_n) begin
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!hold_taken && sb.words_in >= 300) begin
                stall_left = LONG_HOLD;
                hold_taken = 1'b1;
            end else begin
                stall_left = pick_gap();
            end
            i_m_axis_tready <= i_rst_n && (stall_left == 0);
        end
    end

    // Offer one word and wait for it to be taken
    task automatic send_angle(input logic [31:0] angle, input logic kind);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= angle;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_angle(angle, kind);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random angle, weighted towards the interesting regions
    function automatic logic [31:0] pick_angle();
        int          roll;
        logic [31:0] mag;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return $urandom;
        end else if (roll < 70) begin
            mag = $urandom_range(0, ANG_SPAN);
        end else if (roll < 90) begin
            // near a multiple of a quarter turn, either side
            mag = $urandom_range(0, 75) * ANG_HALF_PI + $urandom_range(0, 128) - 64;
        end else begin
            mag = $urandom_range(0, 255);
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial begin
        logic [31:0] dir_angle [12];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, quarter-turn points, fold edges, both kinds
        dir_angle = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                      32'h00000001, ANG_HALF_PI, ANG_PI, ANG_PI + 32'd1,
                      ANG_PI - 32'd1, ANG_TWO_PI, -ANG_PI, -ANG_TWO_PI - 32'd1};
        foreach (dir_angle[i]) begin
            send_angle(dir_angle[i], KIND_COS);
            send_angle(dir_angle[i], KIND_SIN);
        end

        // Random stream with a drain in the middle and a stretch without gaps
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 900) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                wait_drained();
            end
            steady = (n >= 1200 && n < 1500);
            send_angle(pick_angle(), logic'($urandom_range(0, 1)));
        end
        steady = 1'b0;

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.fails == 0 && sb.outstanding() == 0) begin
            $display("PASS sine_cosine_taylor_core");
        end else begin
            $display("FAIL sine_cosine_taylor_core");
        end
        $finish;
    end

endmodule
